// File: sv/nxp_pkg.sv
// ----------------------------------------------------------------------------
// nxp_pkg
// Shared types and constants for the next prime finder.
// ----------------------------------------------------------------------------
package nxp_pkg;

	// width of the value ports
	localparam int PORT_WIDTH = 34;

	// default internal value width
	localparam int VALUE_WIDTH_DEF = 34;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TEST,
		ST_DIV,
		ST_STEP,
		ST_ADV,
		ST_PRIME,
		ST_OVF
	} state_t;

endpackage

// File: sv/next_prime_finder_top.sv
// ----------------------------------------------------------------------------
// next_prime_finder_top
// Finds the smallest prime strictly above a start value by trial division.
// ----------------------------------------------------------------------------
// usage: drive start_value and pulse start while busy is low; that edge
// takes the transaction and busy rises until the result has been shown.
// the result appears on next_prime and overflow for exactly one cycle,
// marked by done; there is no back-pressure, the receiver must take it then.
// overflow is set and next_prime is 0 when no prime above the start value
// fits in VALUE_WIDTH bits; start_value bits at or above VALUE_WIDTH are
// ignored.
// timing: one shared restoring divider tests each odd divisor d with
// d*d <= candidate; each divisor takes a TEST step, a bit-serial division
// in DIV and a STEP to the next divisor and its square. candidates are
// tried upward across the prime gap, so latency is data dependent and grows
// with the candidate and the gap; an all-ones start value goes straight to
// overflow.
// one transaction is in flight at a time.
// reset: arst_n clears the sequencer to idle and abandons any transaction in
// progress; the datapath is not reset, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module next_prime_finder_top #(
	parameter int VALUE_WIDTH = nxp_pkg::VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [nxp_pkg::PORT_WIDTH-1:0] start_value,
	output logic                           done,
	output logic [nxp_pkg::PORT_WIDTH-1:0] next_prime,
	output logic                           overflow
);

	localparam int VW = VALUE_WIDTH;
	localparam int PW = nxp_pkg::PORT_WIDTH;
	localparam int CW = $clog2(VW);
	localparam logic [CW-1:0] CNT_LAST = CW'(VW - 1);

	nxp_pkg::state_t state_q, state_nxt;

	logic [VW-1:0]   cand_q;
	logic [VW-1:0]   div_q;
	logic [VW+1:0]   sq_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   quo_q;
	logic [CW-1:0]   cnt_q;

	logic [VW+PW-1:0] start_wide;
	logic [VW-1:0]    start_ext;
	logic [VW+PW-1:0] res_wide;
	logic             take;
	logic             start_full;
	logic             cand_full;
	logic [VW:0]      trial;
	logic [VW:0]      trial_sub;
	logic             trial_ge;
	logic             sq_over;
	logic [VW+1:0]    sq_nxt;

	// start value trimmed or zero-extended to the internal width
	assign start_wide = {{VW{1'b0}}, start_value};
	assign start_ext  = start_wide[VW-1:0];
	assign res_wide   = {{PW{1'b0}}, cand_q};

	assign take       = start && (state_q == nxp_pkg::ST_IDLE);
	assign start_full = (start_ext == {VW{1'b1}});
	assign cand_full  = (cand_q == {VW{1'b1}});

	// one restoring division step
	assign trial     = {rem_q, quo_q[VW-1]};
	assign trial_ge  = (trial >= {1'b0, div_q});
	assign trial_sub = trial - {1'b0, div_q};

	// (d+2)^2 = d^2 + 4d + 4
	assign sq_over = (sq_q > {2'b00, cand_q});
	assign sq_nxt  = sq_q + {div_q, 2'b00} + (VW+2)'(4);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			nxp_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = start_full ? nxp_pkg::ST_OVF : nxp_pkg::ST_CHECK;
				end
			end
			nxp_pkg::ST_CHECK: begin
				if (cand_q < VW'(2)) begin
					state_nxt = nxp_pkg::ST_ADV;
				end else if (cand_q < VW'(4)) begin
					state_nxt = nxp_pkg::ST_PRIME;
				end else if (!cand_q[0]) begin
					state_nxt = nxp_pkg::ST_ADV;
				end else begin
					state_nxt = nxp_pkg::ST_TEST;
				end
			end
			nxp_pkg::ST_TEST: begin
				state_nxt = sq_over ? nxp_pkg::ST_PRIME : nxp_pkg::ST_DIV;
			end
			nxp_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_nxt = nxp_pkg::ST_STEP;
				end
			end
			nxp_pkg::ST_STEP: begin
				state_nxt = (rem_q == '0) ? nxp_pkg::ST_ADV : nxp_pkg::ST_TEST;
			end
			nxp_pkg::ST_ADV: begin
				state_nxt = cand_full ? nxp_pkg::ST_OVF : nxp_pkg::ST_CHECK;
			end
			nxp_pkg::ST_PRIME: begin
				state_nxt = nxp_pkg::ST_IDLE;
			end
			nxp_pkg::ST_OVF: begin
				state_nxt = nxp_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = nxp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy       = 1'b1;
		done       = 1'b0;
		overflow   = 1'b0;
		next_prime = '0;
		case (state_q)
			nxp_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			nxp_pkg::ST_PRIME: begin
				done       = 1'b1;
				next_prime = res_wide[PW-1:0];
			end
			nxp_pkg::ST_OVF: begin
				done     = 1'b1;
				overflow = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nxp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			nxp_pkg::ST_IDLE: begin
				if (take) begin
					cand_q <= start_ext + VW'(1);
				end
			end
			nxp_pkg::ST_CHECK: begin
				div_q <= VW'(3);
				sq_q  <= (VW+2)'(9);
			end
			nxp_pkg::ST_TEST: begin
				rem_q <= '0;
				quo_q <= cand_q;
				cnt_q <= CNT_LAST;
			end
			nxp_pkg::ST_DIV: begin
				rem_q <= trial_ge ? trial_sub[VW-1:0] : trial[VW-1:0];
				quo_q <= {quo_q[VW-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
			nxp_pkg::ST_STEP: begin
				div_q <= div_q + VW'(2);
				sq_q  <= sq_nxt;
			end
			nxp_pkg::ST_ADV: begin
				if (!cand_full) begin
					cand_q <= cand_q + VW'(1);
				end
			end
			default: begin
				cand_q <= cand_q;
			end
		endcase
	end

endmodule

// File: sim/next_prime_finder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_prime_finder_top_tb
// Self-checking bench for the next prime finder: a short table of start values
// (small values, the top of the range, prime gaps) and then random start
// values, mostly small, since latency grows with the square root of the
// candidate. Results are checked against fixed rows or a trial-division predictor.
// ----------------------------------------------------------------------------
module next_prime_finder_top_tb;

	localparam int PW = nxp_pkg::PORT_WIDTH;
	localparam int VW = nxp_pkg::VALUE_WIDTH_DEF;
	localparam logic [PW-1:0] VALUE_MASK = PW'((64'd1 << VW) - 64'd1);
	localparam int RANDOM_COUNT = 80;
	localparam int CYCLE_LIMIT = 20_000_000;
	localparam int DRAIN_CYCLES = 20;
	localparam int DIRECTED_COUNT = 20;

	typedef struct packed {
		logic [PW-1:0] prime;
		logic          ovf;
	} prime_result_t;

	typedef struct packed {
		logic [PW-1:0] value;
		logic          fixed;
		prime_result_t result;
	} directed_row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic [PW-1:0] start_value = '0;
	logic          busy;
	logic          done;
	logic [PW-1:0] next_prime;
	logic          overflow;

	prime_result_t expected_primes[$];
	prime_result_t oldest_prime;
	int            error_count = 0;
	int            cycle_count = 0;
	int            sent_count = 0;

	// fixed rows hold results that follow directly from the definition
	directed_row_t directed_rows [DIRECTED_COUNT] = '{
		'{PW'(0),            1'b1, '{PW'(2), 1'b0}},
		'{PW'(1),            1'b1, '{PW'(2), 1'b0}},
		'{PW'(2),            1'b1, '{PW'(3), 1'b0}},
		'{PW'(3),            1'b1, '{PW'(5), 1'b0}},
		'{VALUE_MASK,        1'b1, '{PW'(0), 1'b1}},
		'{VALUE_MASK - PW'(1), 1'b1, '{PW'(0), 1'b1}},
		'{VALUE_MASK - PW'(2), 1'b1, '{PW'(0), 1'b1}},
		'{PW'(4),            1'b0, '{PW'(0), 1'b0}},
		'{PW'(7),            1'b0, '{PW'(0), 1'b0}},
		'{PW'(8),            1'b0, '{PW'(0), 1'b0}},
		'{PW'(23),           1'b0, '{PW'(0), 1'b0}},
		'{PW'(89),           1'b0, '{PW'(0), 1'b0}},
		'{PW'(113),          1'b0, '{PW'(0), 1'b0}},
		'{PW'(1327),         1'b0, '{PW'(0), 1'b0}},
		'{PW'(4095),         1'b0, '{PW'(0), 1'b0}},
		'{PW'(32749),        1'b0, '{PW'(0), 1'b0}},
		'{PW'(65535),        1'b0, '{PW'(0), 1'b0}},
		'{PW'(524287),       1'b0, '{PW'(0), 1'b0}},
		'{PW'(1048575),      1'b0, '{PW'(0), 1'b0}},
		'{PW'(2097151),      1'b0, '{PW'(0), 1'b0}}
	};

	next_prime_finder_top #(
		.VALUE_WIDTH(VW)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.start_value(start_value),
		.done       (done),
		.next_prime (next_prime),
		.overflow   (overflow)
	);

	always #4 clk = ~clk;

	function automatic bit is_prime_value(input longint unsigned cand);
		longint unsigned divisor;
		if (cand < 2) return 1'b0;
		if (cand < 4) return 1'b1;
		if ((cand & 1) == 0) return 1'b0;
		for (divisor = 3; divisor <= cand / divisor; divisor += 2) begin
			if (cand % divisor == 0) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic prime_result_t predict_next_prime(input logic [PW-1:0] value);
		longint unsigned top;
		longint unsigned cand;
		prime_result_t   res;
		top = 64'(VALUE_MASK);
		cand = 64'(value & VALUE_MASK);
		res.prime = '0;
		res.ovf = 1'b1;
		if (cand == top) return res;
		cand++;
		while (1) begin
			if (is_prime_value(cand)) begin
				res.prime = PW'(cand);
				res.ovf = 1'b0;
				return res;
			end
			if (cand == top) return res;
			cand++;
		end
	endfunction

	// short bursts with start held high between transactions, mixed with random gaps
	function automatic int unsigned draw_gap(input int idx);
		if (idx % 25 < 6) return 0;
		return $urandom_range(0, 9);
	endfunction

	function automatic logic [PW-1:0] draw_start_value();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) return PW'($urandom_range(0, 4095));
		if (pick < 85) return PW'($urandom_range(0, 65535));
		if (pick < 95) return PW'($urandom_range(0, 1048575));
		// top of the range: no prime left, cheap to resolve
		return VALUE_MASK - PW'($urandom_range(0, 2));
	endfunction

	// start stays high across back-to-back transactions when gap is zero
	task automatic issue_start_value(input logic [PW-1:0] value, input prime_result_t res,
			input int unsigned gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		start_value <= value;
		do @(posedge clk); while (busy);
		expected_primes.push_back(res);
		sent_count++;
	endtask

	initial begin
		logic [PW-1:0] value;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			value = directed_rows[i].value;
			issue_start_value(value,
				directed_rows[i].fixed ? directed_rows[i].result : predict_next_prime(value),
				draw_gap(sent_count));
		end

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			value = draw_start_value();
			issue_start_value(value, predict_next_prime(value), draw_gap(sent_count));
		end
		start <= 1'b0;

		while (expected_primes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_primes.size() == 0) begin
				$error("unexpected transaction: next_prime=%0d overflow=%0b",
					next_prime, overflow);
				error_count++;
			end else begin
				oldest_prime = expected_primes.pop_front();
				if (next_prime !== oldest_prime.prime) begin
					$error("next_prime mismatch: expected %0d, actual %0d",
						oldest_prime.prime, next_prime);
					error_count++;
				end
				if (overflow !== oldest_prime.ovf) begin
					$error("overflow mismatch: expected %0b, actual %0b",
						oldest_prime.ovf, overflow);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule
